FILE: src/pip_pkg.sv
// Shared types and constants for the point-in-polygon test core.
package pip_pkg;

   localparam int MAX_SIDES_DEF  = 16;
   localparam int COORD_BITS_DEF = 32;

   localparam int COORD_W     = 32;
   localparam int SLOT_W      = 4;
   localparam int SIDES_W     = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_POLYGON_SIDES = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_KEEP_INSIDE   = CSR_INDEX_W'(1);

   typedef struct packed {
      logic valid;
      logic cmd;
   } q_head_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_DRAIN
   } back_state_type;

endpackage

FILE: src/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/pip_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module pip_front #(
   parameter int MAX_SIDES  = pip_pkg::MAX_SIDES_DEF,
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_command,
   input  logic [pip_pkg::SLOT_W-1:0]     req_vertex_slot,
   input  logic signed [pip_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [pip_pkg::COORD_W-1:0] req_coord_y,
   output pip_pkg::q_head_type            head,
   output logic [$clog2(MAX_SIDES)-1:0]   head_addr,
   output logic [COORD_BITS-1:0]          head_x,
   output logic [COORD_BITS-1:0]          head_y,
   input  logic                           head_pop
);
   import pip_pkg::*;

   localparam int AW  = $clog2(MAX_SIDES);
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   logic                  cmd_q_ff  [QUEUE_DEPTH];
   logic [AW-1:0]         addr_q_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] x_q_ff    [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] y_q_ff    [QUEUE_DEPTH];
   logic [QAW-1:0]        wr_ptr_ff;
   logic [QAW-1:0]        rd_ptr_ff;
   logic [QCW-1:0]        count_ff;

   logic [SLOT_W+AW-1:0]  slot_ext;
   logic                  slot_ok;
   logic                  push;
   logic                  pop;

   assign slot_ext  = (SLOT_W + AW)'(req_vertex_slot);
   assign slot_ok   = 9'(req_vertex_slot) < 9'(MAX_SIDES);
   assign req_ready = (count_ff != QCW'(QUEUE_DEPTH));

   // A load to a slot beyond the table is taken from the channel and dropped here.
   assign push = req_valid && req_ready && (req_command == CMD_TEST || slot_ok);
   assign pop  = head_pop && head.valid;

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff]  <= req_command;
         addr_q_ff[wr_ptr_ff] <= slot_ext[AW-1:0];
         x_q_ff[wr_ptr_ff]    <= req_coord_x[COORD_BITS-1:0];
         y_q_ff[wr_ptr_ff]    <= req_coord_y[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QCW'(1);
            2'b01:   count_ff <= count_ff - QCW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = cmd_q_ff[rd_ptr_ff];
   assign head_addr  = addr_q_ff[rd_ptr_ff];
   assign head_x     = x_q_ff[rd_ptr_ff];
   assign head_y     = y_q_ff[rd_ptr_ff];

endmodule

FILE: src/pip_back.sv
// Back end: vertex table, edge-walk sequencer, crossing pipeline and result register.
module pip_back #(
   parameter int MAX_SIDES  = pip_pkg::MAX_SIDES_DEF,
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pip_pkg::q_head_type           head,
   input  logic [$clog2(MAX_SIDES)-1:0]  head_addr,
   input  logic [COORD_BITS-1:0]         head_x,
   input  logic [COORD_BITS-1:0]         head_y,
   output logic                          head_pop,
   input  logic [pip_pkg::SIDES_W-1:0]   polygon_sides,
   input  logic                          keep_inside,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_inside_res,
   output logic                          rsp_keep
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_SIDES);
   localparam int CW = $clog2(MAX_SIDES + 1);
   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;

   back_state_type state_ff, state_in;

   logic ram_we, ram_re, start_test, emit;
   logic [2*CB-1:0] ram_rdata;

   logic [CB-1:0] px_ff, py_ff;
   logic [CW-1:0] n_ff, n_sat, nm1;
   logic [AW-1:0] idx_ff;
   logic          first_ff;
   logic          last_idx;

   logic          rd_vld_ff, rd_first_ff;
   logic [CB-1:0] prev_x_ff, prev_y_ff;

   logic signed [CB-1:0] xi, yi, xj, yj, px, py;
   logic                 straddle, near;

   logic                 b_vld_ff, b_act_ff, b_pos_ff;
   logic signed [DW-1:0] b_dyi_ff, b_dxji_ff, b_dxi_ff, b_dy_ff;

   logic                 c_vld_ff, c_act_ff, c_pos_ff;
   logic signed [PW-1:0] lhs_ff, rhs_ff, lhs_in, rhs_in;
   logic signed [PW:0]   cmp_diff;
   logic                 left;

   logic parity_ff;
   logic rsp_valid_ff, rsp_inside_ff, rsp_keep_ff;
   logic pipe_empty, out_free;

   pip_ram #(
      .WIDTH (2 * CB),
      .DEPTH (MAX_SIDES)
   ) u_vertex_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (head_addr),
      .wdata ({head_y, head_x}),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign n_sat = (9'(polygon_sides) > 9'(MAX_SIDES)) ? CW'(MAX_SIDES) : CW'(polygon_sides);
   assign nm1   = n_sat - CW'(1);

   assign last_idx   = (CW'(idx_ff) == n_ff - CW'(1));
   assign pipe_empty = !rd_vld_ff && !b_vld_ff && !c_vld_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid && head.cmd == CMD_TEST) begin
               state_in = (n_sat == '0) ? BK_DRAIN : BK_WALK;
            end
         end
         BK_WALK: begin
            if (!first_ff && last_idx) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (pipe_empty && out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      head_pop   = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      start_test = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            head_pop   = head.valid;
            ram_we     = head.valid && head.cmd == CMD_LOAD;
            start_test = head.valid && head.cmd == CMD_TEST;
         end
         BK_WALK: begin
            ram_re = 1'b1;
         end
         BK_DRAIN: begin
            emit = pipe_empty && out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The walk reads the closing vertex first, then every vertex in order.
   always_ff @(posedge clock) begin
      if (start_test) begin
         px_ff    <= head_x;
         py_ff    <= head_y;
         n_ff     <= n_sat;
         idx_ff   <= nm1[AW-1:0];
         first_ff <= 1'b1;
      end else if (ram_re) begin
         if (first_ff) begin
            idx_ff   <= '0;
            first_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + AW'(1);
         end
      end
   end

   assign xi = ram_rdata[CB-1:0];
   assign yi = ram_rdata[2*CB-1:CB];
   assign xj = prev_x_ff;
   assign yj = prev_y_ff;
   assign px = px_ff;
   assign py = py_ff;

   assign straddle = (yi < py && yj >= py) || (yj < py && yi >= py);
   assign near     = (xi <= px) || (xj <= px);

   always_ff @(posedge clock) begin
      rd_first_ff <= first_ff;
      if (rd_vld_ff) begin
         prev_x_ff <= ram_rdata[CB-1:0];
         prev_y_ff <= ram_rdata[2*CB-1:CB];
      end
      b_act_ff  <= straddle && near;
      b_pos_ff  <= yj > yi;
      b_dyi_ff  <= {py[CB-1], py} - {yi[CB-1], yi};
      b_dxji_ff <= {xj[CB-1], xj} - {xi[CB-1], xi};
      b_dxi_ff  <= {px[CB-1], px} - {xi[CB-1], xi};
      b_dy_ff   <= {yj[CB-1], yj} - {yi[CB-1], yi};
      c_act_ff  <= b_act_ff;
      c_pos_ff  <= b_pos_ff;
      lhs_ff    <= lhs_in;
      rhs_ff    <= rhs_in;
   end

   assign lhs_in = PW'(b_dyi_ff) * PW'(b_dxji_ff);
   assign rhs_in = PW'(b_dxi_ff) * PW'(b_dy_ff);

   // The crossing lies left of the point when the sign-corrected products order so.
   assign cmp_diff = {lhs_ff[PW-1], lhs_ff} - {rhs_ff[PW-1], rhs_ff};
   assign left     = c_pos_ff ? cmp_diff[PW] : (!cmp_diff[PW] && cmp_diff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ram_re;
         b_vld_ff  <= rd_vld_ff && !rd_first_ff;
         c_vld_ff  <= b_vld_ff;
         if (start_test) begin
            parity_ff <= 1'b0;
         end else if (c_vld_ff && c_act_ff && left) begin
            parity_ff <= ~parity_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_inside_ff <= parity_ff;
         rsp_keep_ff   <= (parity_ff == keep_inside);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_keep       = rsp_keep_ff;

endmodule

FILE: src/point_in_polygon_test_core.sv
// Top level of the point-in-polygon test core: configuration registers and the two halves.
//
//   channel  direction  payload                                          beat completes
//   req_     in         command, vertex_slot, coord_x, coord_y           req_valid & req_ready
//   rsp_     out        inside_res, keep                                 rsp_valid & rsp_ready
//   csr_     in         index, wdata                                     csr_valid & csr_ready
//
// A load beat is written to the vertex table when the back end pops it; a test walks polygon_sides
// edges, with the sides capped at MAX_SIDES, and skips the walk when there are none. The vertex
// RAM's single read port walks one vertex per cycle through a three-stage crossing pipeline.
// Reset is synchronous and clears control state only; the vertex table holds whatever was last
// loaded. A two-beat queue between the halves keeps requests flowing while the back end walks
// or waits on a stalled result.
module point_in_polygon_test_core #(
   parameter int MAX_SIDES  = pip_pkg::MAX_SIDES_DEF,
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [pip_pkg::SLOT_W-1:0]          req_vertex_slot,
   input  logic signed [pip_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [pip_pkg::COORD_W-1:0]  req_coord_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_inside_res,
   output logic                                rsp_keep,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pip_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pip_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_SIDES);

   logic [SIDES_W-1:0]    polygon_sides_ff;
   logic                  keep_inside_ff;

   q_head_type            head;
   logic [AW-1:0]         head_addr;
   logic [COORD_BITS-1:0] head_x, head_y;
   logic                  head_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         polygon_sides_ff <= '0;
         keep_inside_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_POLYGON_SIDES) begin
            polygon_sides_ff <= csr_wdata[SIDES_W-1:0];
         end else if (csr_index == REG_KEEP_INSIDE) begin
            keep_inside_ff <= csr_wdata[0];
         end
      end
   end

   pip_front #(
      .MAX_SIDES  (MAX_SIDES),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_vertex_slot (req_vertex_slot),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .head            (head),
      .head_addr       (head_addr),
      .head_x          (head_x),
      .head_y          (head_y),
      .head_pop        (head_pop)
   );

   pip_back #(
      .MAX_SIDES  (MAX_SIDES),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_addr      (head_addr),
      .head_x         (head_x),
      .head_y         (head_y),
      .head_pop       (head_pop),
      .polygon_sides  (polygon_sides_ff),
      .keep_inside    (keep_inside_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_inside_res (rsp_inside_res),
      .rsp_keep       (rsp_keep)
   );

   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("back end popped an empty queue");

   a_keep_matches_mode : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_keep == (rsp_inside_res == keep_inside_ff)))
      else $error("keep flag disagrees with parity and clip mode");

   a_no_result_after_reset : assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result beat pending straight after reset");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the point-in-polygon test core, with its own crossing-parity predictor.
module testbench;
   import pip_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 48;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 300;
   localparam int REPORT_LIMIT = 10;

   localparam logic signed [COORD_W-1:0] ONE       = 32'sh0001_0000;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic inside_res;
      logic keep;
   } pip_result_type;

   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        req_valid       = 1'b0;
   logic                        req_ready;
   logic                        req_command     = CMD_LOAD;
   logic [SLOT_W-1:0]           req_vertex_slot = '0;
   logic signed [COORD_W-1:0]   req_coord_x     = '0;
   logic signed [COORD_W-1:0]   req_coord_y     = '0;
   logic                        rsp_valid;
   logic                        rsp_ready       = 1'b0;
   logic                        rsp_inside_res;
   logic                        rsp_keep;
   logic                        csr_valid       = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index       = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata       = '0;

   // Predictor state: vertex table, register copies and the results still owed.
   logic signed [COORD_W-1:0]   poly_x [MAX_SIDES_DEF];
   logic signed [COORD_W-1:0]   poly_y [MAX_SIDES_DEF];
   logic [SIDES_W-1:0]          sides_reg       = '0;
   logic                        keep_inside_reg = 1'b1;
   pip_result_type              expected_results [$];

   int  mismatch_count   = 0;
   int  result_count     = 0;
   int  items_sent       = 0;
   int  rsp_hold_request = 0;
   bit  req_idling       = 1'b1;
   bit  rsp_idling       = 1'b1;

   point_in_polygon_test_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_vertex_slot (req_vertex_slot),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_keep        (rsp_keep),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Even-odd parity of a horizontal ray cast leftwards from the point, compared exactly.
   function automatic logic ray_parity(input logic signed [COORD_W-1:0] px,
                                       input logic signed [COORD_W-1:0] py);
      int                 n;
      int                 j;
      logic               par;
      logic               straddle;
      logic               left;
      longint             x, y, xi, yi, xj, yj, dy;
      logic signed [127:0] a, b, c, d, lhs, rhs;
      n   = (sides_reg > MAX_SIDES_DEF) ? MAX_SIDES_DEF : int'(sides_reg);
      par = 1'b0;
      if (n == 0)
         return 1'b0;
      x = longint'(px);
      y = longint'(py);
      j = n - 1;
      for (int i = 0; i < n; i++) begin
         xi = longint'(poly_x[i]);
         yi = longint'(poly_y[i]);
         xj = longint'(poly_x[j]);
         yj = longint'(poly_y[j]);
         straddle = (yi < y && yj >= y) || (yj < y && yi >= y);
         if (straddle && (xi <= x || xj <= x)) begin
            dy  = yj - yi;
            a   = 128'(y - yi);
            b   = 128'(xj - xi);
            c   = 128'(x - xi);
            d   = 128'(dy);
            lhs = a * b;
            rhs = c * d;
            left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            par  = par ^ left;
         end
         j = i;
      end
      return par;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Style 0: small box, 1: full range, 2: whole-unit grid, 3: extremes mixed with noise.
   function automatic logic signed [COORD_W-1:0] pick_coord(input int style);
      logic signed [COORD_W-1:0] v;
      case (style)
         0: v = int'($urandom_range(0, 1048576)) - 524288;
         1: v = $urandom();
         2: v = (int'($urandom_range(0, 16)) - 8) * 65536;
         default: begin
            case ($urandom_range(0, 3))
               0: v = COORD_MIN;
               1: v = COORD_MAX;
               2: v = '0;
               default: v = $urandom();
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      logic           par;
      pip_result_type owed;
      if (req_idling && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_vertex_slot <= slot;
      req_coord_x     <= x;
      req_coord_y     <= y;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (cmd == CMD_LOAD) begin
         poly_x[slot] = x;
         poly_y[slot] = y;
      end else begin
         par             = ray_parity(x, y);
         owed.inside_res = par;
         owed.keep       = (par == keep_inside_reg);
         expected_results.insert(expected_results.size(), owed);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      if (index == REG_POLYGON_SIDES)
         sides_reg = data[SIDES_W-1:0];
      else if (index == REG_KEEP_INSIDE)
         keep_inside_reg = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Loads give no result, so a fixed drain follows the last result before the core is idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_polygon_phase(input logic [SIDES_W-1:0] sides_value, input int point_count);
      int                        n;
      int                        style;
      int                        k;
      int                        k2;
      int                        sel;
      longint                    mid;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      wait_idle();
      req_idling = ($urandom_range(0, 9) < 7);
      rsp_idling = ($urandom_range(0, 9) < 7);
      csr_write(REG_POLYGON_SIDES, {3'($urandom_range(0, 7)), sides_value});
      csr_write(REG_KEEP_INSIDE, {7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))});
      n     = (sides_value > MAX_SIDES_DEF) ? MAX_SIDES_DEF : int'(sides_value);
      style = $urandom_range(0, 3);
      for (int s = 0; s < n; s++)
         send_item(CMD_LOAD, SLOT_W'(s), pick_coord(style), pick_coord(style));
      for (int p = 0; p < point_count; p++) begin
         if ($urandom_range(0, 9) == 0) begin
            // Reshape the polygon mid-stream; the loaded vertices stay in order with the tests.
            send_item(CMD_LOAD, SLOT_W'($urandom_range(0, MAX_SIDES_DEF - 1)),
                      pick_coord(style), pick_coord(style));
         end else begin
            sel = $urandom_range(0, 9);
            k   = (n > 0) ? $urandom_range(0, n - 1) : 0;
            k2  = (k == 0) ? n - 1 : k - 1;
            if (n == 0 || sel < 4) begin
               px = pick_coord(style);
               py = pick_coord(style);
            end else if (sel < 6) begin
               px = pick_coord(style);
               py = poly_y[k];
            end else if (sel < 7) begin
               px = poly_x[k];
               py = poly_y[k];
            end else if (sel < 9) begin
               mid = (longint'(poly_x[k]) + longint'(poly_x[k2])) >>> 1;
               px  = mid[COORD_W-1:0];
               mid = (longint'(poly_y[k]) + longint'(poly_y[k2])) >>> 1;
               py  = mid[COORD_W-1:0];
            end else begin
               px = $urandom();
               py = $urandom();
            end
            send_item(CMD_TEST, SLOT_W'($urandom()), px, py);
         end
      end
   endtask

   task automatic test_empty_polygon();
      // Straight out of reset: no sides and the inside points kept.
      send_item(CMD_TEST, '0, '0, '0);
      send_item(CMD_TEST, '1, COORD_MIN, COORD_MAX);
   endtask

   task automatic test_unit_square();
      wait_idle();
      csr_write(REG_POLYGON_SIDES, 8'd4);
      send_item(CMD_LOAD, 4'd0, '0, '0);
      send_item(CMD_LOAD, 4'd1, 4 * ONE, '0);
      send_item(CMD_LOAD, 4'd2, 4 * ONE, 4 * ONE);
      send_item(CMD_LOAD, 4'd3, '0, 4 * ONE);
      send_item(CMD_TEST, '0, 2 * ONE, 2 * ONE);
      send_item(CMD_TEST, '0, 5 * ONE, 2 * ONE);
      send_item(CMD_TEST, '0, -ONE, 2 * ONE);
      send_item(CMD_TEST, '0, 2 * ONE, '0);
      send_item(CMD_TEST, '0, '0, 2 * ONE);
      send_item(CMD_TEST, '0, 4 * ONE, 4 * ONE);
      wait_idle();
      csr_write(REG_KEEP_INSIDE, 8'd0);
      send_item(CMD_TEST, '0, 2 * ONE, 2 * ONE);
      send_item(CMD_TEST, '0, 2 * ONE, -ONE);
   endtask

   task automatic test_extreme_coords();
      wait_idle();
      csr_write(REG_POLYGON_SIDES, 8'd3);
      csr_write(REG_KEEP_INSIDE, 8'd1);
      send_item(CMD_LOAD, 4'd0, COORD_MIN, COORD_MIN);
      send_item(CMD_LOAD, 4'd1, COORD_MAX, COORD_MIN);
      send_item(CMD_LOAD, 4'd2, '0, COORD_MAX);
      send_item(CMD_TEST, '0, '0, '0);
      send_item(CMD_TEST, '0, COORD_MAX, COORD_MAX);
      send_item(CMD_TEST, '0, COORD_MIN, COORD_MIN);
      send_item(CMD_TEST, '0, COORD_MIN, COORD_MAX);
   endtask

   task automatic test_unknown_registers();
      wait_idle();
      for (int idx = 2; idx < (1 << CSR_INDEX_W); idx++)
         csr_write(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom_range(0, 255)));
      send_item(CMD_TEST, '0, '0, ONE);
      send_item(CMD_TEST, '0, COORD_MAX, '0);
   endtask

   task automatic test_side_saturation();
      run_polygon_phase(5'd31, 12);
      run_polygon_phase(SIDES_W'($urandom_range(MAX_SIDES_DEF + 1, 30)), 12);
      run_polygon_phase(SIDES_W'(MAX_SIDES_DEF), 12);
   endtask

   task automatic test_random_polygons();
      int start;
      int r;
      logic [SIDES_W-1:0] sides_value;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            sides_value = SIDES_W'($urandom_range(0, 2));
         else if (r == 1)
            sides_value = SIDES_W'($urandom_range(MAX_SIDES_DEF + 1, 31));
         else
            sides_value = SIDES_W'($urandom_range(3, MAX_SIDES_DEF));
         run_polygon_phase(sides_value, $urandom_range(10, 30));
      end
   endtask

   task automatic test_result_backpressure();
      wait_idle();
      req_idling       = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      // The sender keeps offering beats until the core fills and lowers req_ready.
      for (int p = 0; p < 24; p++)
         send_item(CMD_TEST, '0, pick_coord(0), pick_coord(2));
      wait_idle();
      req_idling = 1'b1;
   endtask

   // Result receiver: random stalls, plus a long hold counted here when one is requested.
   initial begin : rsp_ready_driver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (rsp_hold_request > 0) begin
            rsp_ready <= 1'b0;
            hold_left        = rsp_hold_request - 1;
            rsp_hold_request = 0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_idling && $urandom_range(0, 99) < 20)
               stall_left = gap_length();
         end
      end
   end

   always @(posedge clock) begin : result_checker
      pip_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_failure($sformatf("result %0d: no result expected, got inside_res %b keep %b",
                                     result_count, rsp_inside_res, rsp_keep));
         end else begin
            want = expected_results.pop_front();
            if (rsp_inside_res !== want.inside_res || rsp_keep !== want.keep)
               report_failure($sformatf(
                  "result %0d: inside_res expected %b got %b, keep expected %b got %b",
                  result_count, want.inside_res, rsp_inside_res, want.keep, rsp_keep));
         end
         result_count++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_polygon();
      test_unit_square();
      test_extreme_coords();
      test_unknown_registers();
      test_side_saturation();
      test_random_polygons();
      test_result_backpressure();
      wait_idle();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
src/pip_pkg.sv
src/pip_ram.sv
src/pip_front.sv
src/pip_back.sv
src/point_in_polygon_test_core.sv
dv/testbench.sv
